// File: rtl/tiny_mlp_sigmoid_classifier_unit_defines.svh
// Assertion macros shared by the classifier RTL.
// Needs clk_i and rst_ni in the scope of the module that uses them.
`ifndef TINY_MLP_SIGMOID_CLASSIFIER_UNIT_DEFINES_SVH
`define TINY_MLP_SIGMOID_CLASSIFIER_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset only.
`define TMSC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tmsc assertion failed");

// Next-cycle implication, checked out of reset only.
`define TMSC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tmsc assertion failed");

`endif

// File: rtl/tmsc_pkg.sv
// Package for the tiny perceptron classifier: item types, widths, sequencer states.
// No dependencies; imported by every module of the block.
package tmsc_pkg;

  localparam int NUM_FEATURES_DEF    = 3;
  localparam int NUM_HIDDEN_DEF      = 7;
  localparam int SIGMOID_ENTRIES_DEF = 256;

  localparam int IDX_W   = 5;   // weight index field
  localparam int W_W     = 16;  // Q4.12 weights and features
  localparam int ACT_W   = 13;  // unsigned Q1.12 activation, 0..4096
  localparam int OPA_W   = 17;  // shared multiplier operand A
  localparam int PROD_W  = OPA_W + W_W;
  localparam int SCORE_W = 40;  // accumulator and score
  localparam int SAT_W   = 28;  // offset hidden sum after clamping to [-8, 8)

  localparam logic signed [SCORE_W-1:0] SAT_HI  = 40'sd134217727;
  localparam logic signed [SCORE_W-1:0] SAT_LO  = -40'sd134217728;
  localparam logic signed [SCORE_W-1:0] SAT_OFF = 40'sd134217728;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_PREDICT = 1'b1;

  typedef struct packed {
    logic                    op;
    logic [IDX_W-1:0]        weight_index;
    logic signed [W_W-1:0]   weight_value;
    logic signed [W_W-1:0]   feature_a;
    logic signed [W_W-1:0]   feature_b;
    logic signed [W_W-1:0]   feature_c;
  } in_t;

  typedef struct packed {
    logic                      decide_jump;
    logic signed [SCORE_W-1:0] score;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HID,
    ST_WAIT,
    ST_OUT,
    ST_FIN
  } seq_state_e;

  // Tags that travel with each operand pair through the MAC
  typedef struct packed {
    logic vld;
    logic first;
    logic last;
    logic score;
  } mac_ctrl_t;

  typedef struct packed {
    logic done;
    logic score;
  } mac_stat_t;

endpackage

// File: rtl/tmsc_mac.sv
// Shared multiply-accumulate unit: registered 17x16 product, then 40-bit accumulate.
// Depends on tmsc_pkg.
module tmsc_mac (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  tmsc_pkg::mac_ctrl_t                ctrl_i,
  input  logic signed [tmsc_pkg::OPA_W-1:0]  op_a_i,
  input  logic signed [tmsc_pkg::W_W-1:0]    op_b_i,
  output logic signed [tmsc_pkg::SCORE_W-1:0] acc_o,
  output tmsc_pkg::mac_stat_t                stat_o
);
  import tmsc_pkg::*;

  logic signed [PROD_W-1:0]  prod_d, prod_q;
  logic signed [SCORE_W-1:0] acc_d, acc_q;
  mac_ctrl_t                 ctrl_q;
  mac_stat_t                 stat_d, stat_q;

  assign prod_d = op_a_i * op_b_i;

  always_comb begin
    acc_d = acc_q;
    if (ctrl_q.vld) begin
      // restart the sum on the first term of a group
      acc_d = (ctrl_q.first ? '0 : acc_q) + SCORE_W'(prod_q);
    end
  end

  assign stat_d.done  = ctrl_q.vld & ctrl_q.last;
  assign stat_d.score = ctrl_q.score;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
      stat_q <= '0;
    end else begin
      ctrl_q <= ctrl_i;
      stat_q <= stat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
  end

  assign acc_o  = acc_q;
  assign stat_o = stat_q;

endmodule

// File: rtl/tmsc_act.sv
// Hidden activation path: clamp the sum, scale to a table index, read the sigmoid table.
// Depends on tmsc_pkg; the table is built from constants at elaboration.
module tmsc_act #(
  parameter int SIGMOID_ENTRIES = tmsc_pkg::SIGMOID_ENTRIES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                sum_vld_i,
  input  logic signed [tmsc_pkg::SCORE_W-1:0] sum_i,
  output logic                                act_vld_o,
  output logic [tmsc_pkg::ACT_W-1:0]          act_o
);
  import tmsc_pkg::*;

  localparam int EW = $clog2(SIGMOID_ENTRIES);
  localparam int MW = SAT_W + EW;

  logic [ACT_W-1:0]          rom [SIGMOID_ENTRIES];
  logic signed [SCORE_W-1:0] sat;
  logic [SAT_W-1:0]          off_d, off_q;
  logic [MW-1:0]             idx_prod;
  logic [EW-1:0]             idx_d, idx_q;
  logic [ACT_W-1:0]          act_q;
  logic                      v1_q, v2_q, v3_q;

  // Entry k samples the sigmoid at the middle of bin k; e^a from a Taylor
  // series of e^(a/16) in Q40, cut to Q24 and squared four times.
  for (genvar k = 0; k < SIGMOID_ENTRIES; k++) begin : g_rom
    localparam longint NUM = longint'(16 * k + 8) - longint'(8 * SIGMOID_ENTRIES);
    localparam bit [63:0] MAG = (NUM >= 0) ? 64'(NUM) : 64'(-NUM);
    localparam bit [63:0] DEN = 64'(16 * SIGMOID_ENTRIES);
    localparam bit [63:0] T0  = 64'd1 << 40;
    localparam bit [63:0] T1  = T0  * MAG / (DEN * 64'd1);
    localparam bit [63:0] T2  = T1  * MAG / (DEN * 64'd2);
    localparam bit [63:0] T3  = T2  * MAG / (DEN * 64'd3);
    localparam bit [63:0] T4  = T3  * MAG / (DEN * 64'd4);
    localparam bit [63:0] T5  = T4  * MAG / (DEN * 64'd5);
    localparam bit [63:0] T6  = T5  * MAG / (DEN * 64'd6);
    localparam bit [63:0] T7  = T6  * MAG / (DEN * 64'd7);
    localparam bit [63:0] T8  = T7  * MAG / (DEN * 64'd8);
    localparam bit [63:0] T9  = T8  * MAG / (DEN * 64'd9);
    localparam bit [63:0] T10 = T9  * MAG / (DEN * 64'd10);
    localparam bit [63:0] T11 = T10 * MAG / (DEN * 64'd11);
    localparam bit [63:0] T12 = T11 * MAG / (DEN * 64'd12);
    localparam bit [63:0] T13 = T12 * MAG / (DEN * 64'd13);
    localparam bit [63:0] T14 = T13 * MAG / (DEN * 64'd14);
    localparam bit [63:0] T15 = T14 * MAG / (DEN * 64'd15);
    localparam bit [63:0] T16 = T15 * MAG / (DEN * 64'd16);
    localparam bit [63:0] T17 = T16 * MAG / (DEN * 64'd17);
    localparam bit [63:0] T18 = T17 * MAG / (DEN * 64'd18);
    localparam bit [63:0] T19 = T18 * MAG / (DEN * 64'd19);
    localparam bit [63:0] T20 = T19 * MAG / (DEN * 64'd20);
    localparam bit [63:0] SUMT = T0 + T1 + T2 + T3 + T4 + T5 + T6 + T7 + T8 + T9 + T10
                               + T11 + T12 + T13 + T14 + T15 + T16 + T17 + T18 + T19 + T20;
    localparam bit [63:0] E0 = SUMT >> 16;
    localparam bit [63:0] E1 = (E0 * E0) >> 24;
    localparam bit [63:0] E2 = (E1 * E1) >> 24;
    localparam bit [63:0] E3 = (E2 * E2) >> 24;
    localparam bit [63:0] E4 = (E3 * E3) >> 24;
    localparam bit [63:0] DD = E4 + (64'd1 << 24);
    localparam bit [63:0] P  = (64'd4096 * E4 + DD / 64'd2) / DD;
    localparam bit [63:0] VAL = (NUM >= 0) ? P : (64'd4096 - P);
    assign rom[k] = ACT_W'(VAL);
  end

  always_comb begin
    sat = sum_i;
    if (sum_i < SAT_LO) begin
      sat = SAT_LO;
    end else if (sum_i > SAT_HI) begin
      sat = SAT_HI;
    end
  end

  assign off_d    = SAT_W'(sat + SAT_OFF);
  assign idx_prod = MW'(off_q) * MW'(SIGMOID_ENTRIES);
  assign idx_d    = idx_prod[MW-1 -: EW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= sum_vld_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    off_q <= off_d;
    idx_q <= idx_d;
    act_q <= rom[idx_q];
  end

  assign act_vld_o = v3_q;
  assign act_o     = act_q;

endmodule

// File: rtl/tiny_mlp_sigmoid_classifier_unit.sv
// Top level of the tiny perceptron classifier: sequencer, weight store, activation buffer.
// Depends on tmsc_pkg, tmsc_mac, tmsc_act and the assertion macro header.
//
// Usage: drive item_i and raise start; the item is taken on a rising edge where
// start is high and busy is low.
// A load item (op = 0) writes weight_value at weight_index and gives
// no result; busy stays low, so loads may follow back to back. Indices past the
// last output weight are dropped.
// A predict item (op = 1) raises busy and runs all hidden and output
// multiply-accumulates on one shared MAC. The result appears on result_o with
// result_valid_o high for exactly one cycle; busy falls in that same cycle, so a
// new item can be taken alongside it. The delay to the result is set by the single
// MAC issuing one product a cycle, except while it waits for the hidden
// activations, plus the memory, multiplier, accumulator and table stages.
// The receiver cannot stall: the strobed result must be taken when shown.
// Reset (rst_ni low) returns the sequencer to idle and drops any prediction in
// flight; the weight store is not cleared, so weights must be loaded before use.
`include "tiny_mlp_sigmoid_classifier_unit_defines.svh"

module tiny_mlp_sigmoid_classifier_unit #(
  parameter int NUM_FEATURES    = tmsc_pkg::NUM_FEATURES_DEF,
  parameter int NUM_HIDDEN      = tmsc_pkg::NUM_HIDDEN_DEF,
  parameter int SIGMOID_ENTRIES = tmsc_pkg::SIGMOID_ENTRIES_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  tmsc_pkg::in_t  item_i,
  output logic           result_valid_o,
  output tmsc_pkg::out_t result_o
);
  import tmsc_pkg::*;

  localparam int NUM_HW = NUM_HIDDEN * NUM_FEATURES;
  localparam int NUM_W  = NUM_HW + NUM_HIDDEN;
  localparam int AW     = $clog2(NUM_W);
  localparam int XW     = (AW > IDX_W) ? AW : IDX_W;
  localparam int CW     = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;
  localparam int HW     = (NUM_HIDDEN > 1) ? $clog2(NUM_HIDDEN) : 1;
  localparam int CNTW   = $clog2(NUM_HIDDEN + 1);

  seq_state_e state_d, state_q;

  logic [CW-1:0]   col_d, col_q, iss_col_q;
  logic [HW-1:0]   hid_d, hid_q, iss_hid_q;
  logic [AW-1:0]   addr_d, addr_q;
  logic [CNTW-1:0] act_cnt_d, act_cnt_q;
  logic            col_last, hid_last;
  logic            accept, accept_pred, wr_en;
  logic [XW-1:0]   idx_x;

  mac_ctrl_t iss_ctrl_d, iss_ctrl_q;
  mac_stat_t mac_stat;

  logic [W_W-1:0]          wmem_q [NUM_W];
  logic [W_W-1:0]          rdata_q;
  logic signed [W_W-1:0]   feat_a_q, feat_b_q, feat_c_q;
  logic [ACT_W-1:0]        act_q [NUM_HIDDEN];
  logic signed [OPA_W-1:0] op_a;
  logic signed [SCORE_W-1:0] mac_acc;
  logic                    act_vld;
  logic [ACT_W-1:0]        act_val;
  logic                    res_vld_d, res_vld_q;
  out_t                    res_q;

  assign busy        = (state_q != ST_IDLE);
  assign accept      = start & ~busy;
  assign accept_pred = accept & (item_i.op == OP_PREDICT);
  assign idx_x       = XW'(item_i.weight_index);
  assign wr_en       = accept & (item_i.op == OP_LOAD) & (idx_x < XW'(NUM_W));

  assign col_last = (col_q == CW'(NUM_FEATURES - 1));
  assign hid_last = (hid_q == HW'(NUM_HIDDEN - 1));

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept_pred) state_d = ST_HID;
      end
      ST_HID: begin
        if (hid_last && col_last) state_d = ST_WAIT;
      end
      ST_WAIT: begin
        // hold until every hidden activation has landed
        if (act_cnt_q == CNTW'(NUM_HIDDEN)) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (hid_last) state_d = ST_FIN;
      end
      ST_FIN: begin
        if (mac_stat.done && mac_stat.score) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Issue control and counters
  always_comb begin
    iss_ctrl_d = '0;
    col_d      = col_q;
    hid_d      = hid_q;
    addr_d     = addr_q;
    case (state_q)
      ST_IDLE: begin
        col_d  = '0;
        hid_d  = '0;
        addr_d = '0;
      end
      ST_HID: begin
        iss_ctrl_d.vld   = 1'b1;
        iss_ctrl_d.first = (col_q == '0);
        iss_ctrl_d.last  = col_last;
        iss_ctrl_d.score = 1'b0;
        addr_d = addr_q + AW'(1);
        if (col_last) begin
          col_d = '0;
          hid_d = hid_last ? '0 : hid_q + HW'(1);
        end else begin
          col_d = col_q + CW'(1);
        end
      end
      ST_OUT: begin
        iss_ctrl_d.vld   = 1'b1;
        iss_ctrl_d.first = (hid_q == '0);
        iss_ctrl_d.last  = hid_last;
        iss_ctrl_d.score = 1'b1;
        addr_d = addr_q + AW'(1);
        hid_d  = hid_q + HW'(1);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    act_cnt_d = act_cnt_q;
    if (accept_pred) begin
      act_cnt_d = '0;
    end else if (act_vld) begin
      act_cnt_d = act_cnt_q + CNTW'(1);
    end
  end

  assign res_vld_d = mac_stat.done & mac_stat.score;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      col_q      <= '0;
      hid_q      <= '0;
      addr_q     <= '0;
      act_cnt_q  <= '0;
      iss_ctrl_q <= '0;
      res_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      col_q      <= col_d;
      hid_q      <= hid_d;
      addr_q     <= addr_d;
      act_cnt_q  <= act_cnt_d;
      iss_ctrl_q <= iss_ctrl_d;
      res_vld_q  <= res_vld_d;
    end
  end

  // Weight store: one write port for loads, one registered read port for the MAC
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      wmem_q[idx_x[AW-1:0]] <= item_i.weight_value;
    end
    if (iss_ctrl_d.vld) begin
      rdata_q <= wmem_q[addr_q];
    end
  end

  always_ff @(posedge clk_i) begin
    iss_col_q <= col_q;
    iss_hid_q <= hid_q;
    if (accept_pred) begin
      feat_a_q <= item_i.feature_a;
      feat_b_q <= item_i.feature_b;
      feat_c_q <= item_i.feature_c;
    end
    if (act_vld) begin
      act_q[act_cnt_q[HW-1:0]] <= act_val;
    end
    if (res_vld_d) begin
      res_q.decide_jump <= ~mac_acc[SCORE_W-1];
      res_q.score       <= mac_acc;
    end
  end

  // Operand A: a feature during the hidden layer, an activation for the score
  always_comb begin
    if (iss_ctrl_q.score) begin
      op_a = {{(OPA_W - ACT_W){1'b0}}, act_q[iss_hid_q]};
    end else begin
      case (32'(iss_col_q))
        32'd0:   op_a = {feat_a_q[W_W-1], feat_a_q};
        32'd1:   op_a = {feat_b_q[W_W-1], feat_b_q};
        32'd2:   op_a = {feat_c_q[W_W-1], feat_c_q};
        default: op_a = '0;
      endcase
    end
  end

  tmsc_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (iss_ctrl_q),
    .op_a_i (op_a),
    .op_b_i ($signed(rdata_q)),
    .acc_o  (mac_acc),
    .stat_o (mac_stat)
  );

  tmsc_act #(
    .SIGMOID_ENTRIES (SIGMOID_ENTRIES)
  ) u_act (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .sum_vld_i (mac_stat.done & ~mac_stat.score),
    .sum_i     (mac_acc),
    .act_vld_o (act_vld),
    .act_o     (act_val)
  );

  assign result_valid_o = res_vld_q;
  assign result_o       = res_q;

  `TMSC_ASSERT_IMP(a_res_ends_busy, result_valid_o, $past(busy))
  `TMSC_ASSERT_NXT(a_pred_sets_busy, accept_pred, busy)
  `TMSC_ASSERT_NXT(a_load_no_result, accept && (item_i.op == OP_LOAD), !result_valid_o)
  `TMSC_ASSERT_IMP(a_out_needs_acts, state_q == ST_OUT, act_cnt_q == CNTW'(NUM_HIDDEN))
  `TMSC_ASSERT_IMP(a_act_in_range, act_vld, act_cnt_q < CNTW'(NUM_HIDDEN))

endmodule

// File: tb/tb_tiny_mlp_sigmoid_classifier_unit.sv
`timescale 1ns / 1ps
// Self-checking bench for tiny_mlp_sigmoid_classifier_unit: weight loads and predictions.
// Depends on tmsc_pkg; results are checked against an in-bench perceptron predictor.

module tb_tiny_mlp_sigmoid_classifier_unit;
  import tmsc_pkg::*;

  localparam int HID_N          = NUM_FEATURES_DEF * NUM_HIDDEN_DEF;
  localparam int WEIGHT_N       = HID_N + NUM_HIDDEN_DEF;
  localparam int LATENCY        = HID_N + NUM_HIDDEN_DEF + 11;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int ITEMS_PER_PHASE = 205;

  typedef enum logic {ROW_ITEM, ROW_FILL} row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    in_t                   item;
    logic signed [W_W-1:0] fill_hid;
    logic signed [W_W-1:0] fill_out;
    logic                  typed;
    out_t                  typed_out;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  in_t  item_i;
  logic result_valid_o;
  out_t result_o;

  tiny_mlp_sigmoid_classifier_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .item_i        (item_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Predictor state
  logic signed [W_W-1:0] hid_w [HID_N];
  logic signed [W_W-1:0] out_w [NUM_HIDDEN_DEF];
  logic [ACT_W-1:0]      act_lut [SIGMOID_ENTRIES_DEF];

  out_t      pending_scores[$];
  stim_row_t directed_rows[$];
  int        errors = 0;
  int        stall_cycles = 0;
  out_t      want;

  // round(4096 * e^a / (e^a + 1)), e^(a/16) by Taylor series then squared four times
  function automatic logic [ACT_W-1:0] sigmoid_upper(longint unsigned mag);
    longint unsigned term, sum, e, d, n;
    term = 64'd1 << 40;
    sum  = term;
    for (n = 1; n <= 20; n++) begin
      term = term * mag / (64'd16 * SIGMOID_ENTRIES_DEF * n);
      sum += term;
    end
    e = sum >> 16;
    repeat (4) e = (e * e) >> 24;
    d = e + (64'd1 << 24);
    return ACT_W'((64'd4096 * e + d / 2) / d);
  endfunction

  function automatic out_t classify(in_t it);
    longint feat [NUM_FEATURES_DEF];
    longint acc, total;
    int     h, i, tix;
    out_t   r;
    feat[0] = it.feature_a;
    feat[1] = it.feature_b;
    feat[2] = it.feature_c;
    total = 0;
    for (h = 0; h < NUM_HIDDEN_DEF; h++) begin
      acc = 0;
      for (i = 0; i < NUM_FEATURES_DEF; i++)
        acc += longint'(hid_w[h * NUM_FEATURES_DEF + i]) * feat[i];
      if (acc > SAT_HI) acc = SAT_HI;
      if (acc < SAT_LO) acc = SAT_LO;
      tix = int'(((acc + longint'(SAT_OFF)) * SIGMOID_ENTRIES_DEF) >> SAT_W);
      total += longint'(act_lut[tix]) * longint'(out_w[h]);
    end
    r.decide_jump = (total >= 0);
    r.score       = total[SCORE_W-1:0];
    return r;
  endfunction

  function automatic logic signed [W_W-1:0] rand_q412();
    case ($urandom_range(0, 3))
      0: return W_W'($urandom);
      1: begin
        case ($urandom_range(0, 3))
          0: return 16'sh8000;
          1: return 16'sh7fff;
          2: return '0;
          default: return '1;
        endcase
      end
      default: return W_W'($urandom_range(0, 8192)) - 16'sd4096;
    endcase
  endfunction

  function automatic in_t random_item();
    in_t it;
    it.op           = 1'($urandom);
    it.weight_index = IDX_W'($urandom);
    it.weight_value = W_W'($urandom);
    it.feature_a    = W_W'($urandom);
    it.feature_b    = W_W'($urandom);
    it.feature_c    = W_W'($urandom);
    return it;
  endfunction

  function automatic in_t load_item(logic [IDX_W-1:0] idx, logic signed [W_W-1:0] v);
    in_t it;
    it              = '0;
    it.op           = OP_LOAD;
    it.weight_index = idx;
    it.weight_value = v;
    return it;
  endfunction

  function automatic in_t predict_item(logic signed [W_W-1:0] a, logic signed [W_W-1:0] b,
                                       logic signed [W_W-1:0] c);
    in_t it;
    it           = '0;
    it.op        = OP_PREDICT;
    it.feature_a = a;
    it.feature_b = b;
    it.feature_c = c;
    return it;
  endfunction

  function automatic stim_row_t item_row(in_t it);
    stim_row_t r;
    r      = '0;
    r.kind = ROW_ITEM;
    r.item = it;
    return r;
  endfunction

  function automatic stim_row_t typed_row(in_t it, logic dj, logic signed [SCORE_W-1:0] sc);
    stim_row_t r;
    r                       = item_row(it);
    r.typed                 = 1'b1;
    r.typed_out.decide_jump = dj;
    r.typed_out.score       = sc;
    return r;
  endfunction

  function automatic stim_row_t fill_row(logic signed [W_W-1:0] h, logic signed [W_W-1:0] o);
    stim_row_t r;
    r          = '0;
    r.kind     = ROW_FILL;
    r.fill_hid = h;
    r.fill_out = o;
    return r;
  endfunction

  // Hold the item until taken, then update the predictor
  task automatic issue(in_t it, logic use_typed = 1'b0, out_t typed_out = '0);
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    if (it.op == OP_LOAD) begin
      if (it.weight_index < HID_N)
        hid_w[it.weight_index] = it.weight_value;
      else if (it.weight_index < WEIGHT_N)
        out_w[it.weight_index - HID_N] = it.weight_value;
    end else begin
      pending_scores.push_back(use_typed ? typed_out : classify(it));
    end
  endtask

  task automatic pause(int cycles);
    start  <= 1'b0;
    item_i <= random_item();
    repeat (cycles) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (pending_scores.size() == 0) begin
        errors++;
        $error("result with no prediction pending: score %0d", $signed(result_o.score));
      end else begin
        want = pending_scores.pop_front();
        if (result_o.decide_jump !== want.decide_jump) begin
          errors++;
          $error("decide_jump: expected %0d, got %0d", want.decide_jump, result_o.decide_jump);
        end
        if (result_o.score !== want.score) begin
          errors++;
          $error("score: expected %0d, got %0d", $signed(want.score), $signed(result_o.score));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("tb_tiny_mlp_sigmoid_classifier_unit NOT OK");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int        k, i, phase, counted, r;
    int        idle_pct [4];
    longint    num;
    stim_row_t row;
    in_t       it;

    rst_ni <= 1'b0;
    start  <= 1'b0;
    item_i <= '0;
    idle_pct = '{0, 50, 0, 32};

    for (k = 0; k < SIGMOID_ENTRIES_DEF; k++) begin
      num = 16 * k + 8 - 8 * SIGMOID_ENTRIES_DEF;
      if (num >= 0) act_lut[k] = sigmoid_upper(num);
      else          act_lut[k] = ACT_W'(4096) - sigmoid_upper(-num);
    end

    // Zero output weights give a zero score whatever the features
    directed_rows.push_back(fill_row(16'sd0, 16'sd0));
    directed_rows.push_back(typed_row(predict_item(16'sh7fff, 16'sh8000, 16'sd0), 1'b1, '0));
    directed_rows.push_back(typed_row(predict_item(16'sh8000, 16'sh8000, 16'sh8000), 1'b1,
                                      '0));
    // Zero hidden weights put every neuron on the middle table entry, 2080
    directed_rows.push_back(fill_row(16'sd0, 16'sh7fff));
    directed_rows.push_back(typed_row(predict_item(16'sh7fff, 16'sh7fff, 16'sh7fff), 1'b1,
                                      40'sd477087520));
    directed_rows.push_back(fill_row(16'sd0, 16'sh8000));
    directed_rows.push_back(typed_row(predict_item(-16'sd1, 16'sd1, 16'sd0), 1'b0,
                                      -40'sd477102080));
    // Out-of-range indices must be dropped
    directed_rows.push_back(item_row(load_item(5'd28, 16'sh7fff)));
    directed_rows.push_back(item_row(load_item(5'd31, -16'sd1)));
    directed_rows.push_back(typed_row(predict_item(16'sd0, 16'sd0, 16'sd0), 1'b0,
                                      -40'sd477102080));
    directed_rows.push_back(fill_row(16'sh7fff, 16'sd1));
    directed_rows.push_back(item_row(predict_item(16'sh7fff, 16'sh7fff, 16'sh7fff)));
    directed_rows.push_back(item_row(predict_item(16'sh8000, 16'sh8000, 16'sh8000)));
    directed_rows.push_back(fill_row(16'sh8000, 16'sh8000));
    directed_rows.push_back(item_row(predict_item(16'sh8000, 16'sh8000, 16'sh8000)));
    directed_rows.push_back(item_row(predict_item(16'sh7fff, 16'sd0, 16'sh8000)));
    directed_rows.push_back(item_row(load_item(5'd0, -16'sd1)));
    directed_rows.push_back(item_row(load_item(5'd20, 16'sh4000)));
    directed_rows.push_back(item_row(load_item(5'd21, 16'sh0800)));
    directed_rows.push_back(item_row(load_item(5'd27, -16'sd4096)));
    directed_rows.push_back(item_row(predict_item(16'sd4096, -16'sd4096, 16'sd2048)));
    directed_rows.push_back(item_row(load_item(5'd10, 16'sd1)));
    directed_rows.push_back(item_row(predict_item(16'sd1, -16'sd1, 16'sh7fff)));
    directed_rows.push_back(fill_row(16'sd4096, 16'sd2048));
    directed_rows.push_back(item_row(predict_item(16'sd4096, 16'sd2048, -16'sd3072)));
    directed_rows.push_back(item_row(predict_item(16'sd0, 16'sd0, 16'sd0)));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[k]) begin
      row = directed_rows[k];
      if (row.kind == ROW_FILL) begin
        for (i = 0; i < WEIGHT_N; i++)
          issue(load_item(IDX_W'(i), (i < HID_N) ? row.fill_hid : row.fill_out));
      end else begin
        issue(row.item, row.typed, row.typed_out);
      end
    end

    for (phase = 0; phase < 4; phase++) begin
      counted = 0;
      while (counted < ITEMS_PER_PHASE) begin
        it = random_item();
        r  = $urandom_range(0, 99);
        if (r < 5) begin
          it.op           = OP_LOAD;
          it.weight_index = IDX_W'($urandom_range(WEIGHT_N, 31));
        end else if (r < 40) begin
          it.op           = OP_LOAD;
          it.weight_index = IDX_W'($urandom_range(0, WEIGHT_N - 1));
          it.weight_value = rand_q412();
          counted++;
        end else begin
          it.op        = OP_PREDICT;
          it.feature_a = rand_q412();
          it.feature_b = rand_q412();
          it.feature_c = rand_q412();
          counted++;
        end
        issue(it);
        // Mostly short gaps, now and then one long enough to span a prediction
        if ($urandom_range(0, 99) < idle_pct[phase])
          pause(($urandom_range(0, 3) == 0) ? $urandom_range(1, 45) : $urandom_range(1, 4));
      end
    end

    start <= 1'b0;
    while (pending_scores.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 5) @(posedge clk_i);

    if (errors == 0)
      $display("tb_tiny_mlp_sigmoid_classifier_unit OK");
    else
      $display("tb_tiny_mlp_sigmoid_classifier_unit NOT OK");
    $finish;
  end

endmodule
